>>> rtl/itrt_pkg.sv
// itrt_pkg: request types, character constants and controller/datapath links
// for the integer to radix text converter. No dependencies.

package itrt_pkg;

  localparam int unsigned RadixW        = 6;
  localparam int unsigned ValueInW      = 32;

  // input request: one integer to convert
  typedef struct packed {
    logic signed [ValueInW-1:0] value;
    logic [RadixW-1:0]          radix;
    logic                       upper_letters;
  } in_req_t;

  // output request: one character of the text
  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } out_req_t;

  localparam logic [RadixW-1:0] RadixMin      = 6'd2;
  localparam logic [RadixW-1:0] RadixMax      = 6'd36;
  localparam logic [RadixW-1:0] RadixFallback = 6'd10;

  // quotient bits produced per divider cycle
  localparam int unsigned BitsPerStep = 4;

  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharUpperA = 7'h41;
  localparam logic [6:0] CharLowerA = 7'h61;
  localparam logic [6:0] CharMinus  = 7'h2D;
  localparam logic [RadixW-1:0] DecDigits = 6'd10;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic emit_sign;
    logic rd_issue;
    logic emit_digit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic step_last;
    logic quot_zero;
    logic negative;
    logic stack_last;
    logic out_free;
  } stat_t;

  function automatic logic [6:0] digit_to_char(logic [RadixW-1:0] d, logic upper);
    logic [6:0] base;
    base = upper ? CharUpperA : CharLowerA;
    if (d < DecDigits) begin
      return CharZero + {1'b0, d};
    end
    return base + {1'b0, d - DecDigits};
  endfunction

endpackage

>>> rtl/itrt_ctrl.sv
// itrt_ctrl: sequencer of the converter; drives the datapath by commands
// and follows its status. Depends on itrt_pkg.

module itrt_ctrl import itrt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StPush,
    StSign,
    StRead,
    StLoad
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.step_last) begin
          state_d = StPush;
        end
      end
      StPush: begin
        cmd_o.push = 1'b1;
        if (stat_i.quot_zero) begin
          state_d = stat_i.negative ? StSign : StRead;
        end else begin
          state_d = StDiv;
        end
      end
      StSign: begin
        if (stat_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = StLoad;
      end
      StLoad: begin
        if (stat_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          state_d          = stat_i.stack_last ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/itrt_dp.sv
// itrt_dp: datapath of the converter: magnitude, radix divider, digit stack
// and output register. Depends on itrt_pkg.

module itrt_dp import itrt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_data_i,
  input  cmd_t     cmd_i,
  output stat_t    stat_o,
  output out_req_t out_data_o,
  output logic     out_valid_o,
  input  logic     out_ready_i
);

  // magnitude padded to a whole number of divider steps
  localparam int unsigned NumSteps = (VALUE_WIDTH + BitsPerStep - 1) / BitsPerStep;
  localparam int unsigned PadW     = NumSteps * BitsPerStep;
  localparam int unsigned StepW    = $clog2(NumSteps);
  localparam int unsigned AddrW    = $clog2(VALUE_WIDTH);
  localparam int unsigned PtrW     = $clog2(VALUE_WIDTH + 1);

  logic [PadW-1:0]   mag_q, mag_d;
  logic [RadixW-1:0] rem_q, rem_d;
  logic [RadixW-1:0] radix_q;
  logic              upper_q;
  logic              neg_q;
  logic [StepW-1:0]  step_q;
  logic [PtrW-1:0]   ptr_q;
  logic [RadixW-1:0] rd_q;
  logic [RadixW-1:0] stack_mem [VALUE_WIDTH];
  out_req_t          out_q;
  logic              out_valid_q;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   raw_neg;
  logic [VALUE_WIDTH-1:0] raw_mag;
  logic [RadixW-1:0]      radix_eff;
  logic [PtrW-1:0]        ptr_m1;

  assign raw       = VALUE_WIDTH'(unsigned'(in_data_i.value));
  assign raw_neg   = raw[VALUE_WIDTH-1];
  assign raw_mag   = raw_neg ? (~raw + 1'b1) : raw;
  assign radix_eff = (in_data_i.radix < RadixMin || in_data_i.radix > RadixMax) ?
                     RadixFallback : in_data_i.radix;
  assign ptr_m1    = ptr_q - 1'b1;

  // restoring division, BitsPerStep quotient bits per div_step
  always_comb begin
    logic [RadixW:0]   t;
    logic [RadixW-1:0] r;
    logic [PadW-1:0]   m;
    r = rem_q;
    m = mag_q;
    for (int k = 0; k < BitsPerStep; k++) begin
      t = {r, m[PadW-1]};
      m = {m[PadW-2:0], 1'b0};
      if (t >= {1'b0, radix_q}) begin
        t    = t - {1'b0, radix_q};
        m[0] = 1'b1;
      end
      r = t[RadixW-1:0];
    end
    mag_d = m;
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
        ptr_q  <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end else if (cmd_i.push) begin
        step_q <= '0;
        ptr_q  <= ptr_q + 1'b1;
      end else if (cmd_i.emit_digit) begin
        ptr_q <= ptr_m1;
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= PadW'(raw_mag);
      rem_q   <= '0;
      radix_q <= radix_eff;
      upper_q <= in_data_i.upper_letters;
      neg_q   <= raw_neg;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end else if (cmd_i.push) begin
      rem_q <= '0;
    end
    if (cmd_i.emit_sign) begin
      out_q.text_char <= CharMinus;
      out_q.last_char <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_q.text_char <= digit_to_char(rd_q, upper_q);
      out_q.last_char <= (ptr_q == PtrW'(1));
    end
  end

  // digit stack, least significant pushed first
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[ptr_q[AddrW-1:0]] <= rem_q;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= stack_mem[ptr_m1[AddrW-1:0]];
    end
  end

  assign stat_o.step_last  = (step_q == StepW'(NumSteps - 1));
  assign stat_o.quot_zero  = (mag_q == '0);
  assign stat_o.negative   = neg_q;
  assign stat_o.stack_last = (ptr_q == PtrW'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/integer_to_radix_text.sv
// integer_to_radix_text: top level of the signed integer to ASCII converter.
// Depends on itrt_pkg, itrt_ctrl and itrt_dp.
//
// An input request (value, radix, upper_letters) is taken on in_valid_i and
// in_ready_o. Each character of the text leaves as one output request on
// out_valid_o and out_ready_i: '-' first for a negative value, then the
// digits most significant first; last_char marks the final one.
// A radix outside 2..36 converts in base 10.
// Each digit is computed by repeated steps of the shared radix divider,
// which yields four quotient bits a cycle while it steps; each character then
// passes through the digit stack memory and its registered read port.
// One request is converted at a time; in_ready_o returns high once the last
// character is in the output register, so the next request can be taken
// while that character still waits to be taken.
// A stalled receiver holds the output register and stops the character
// sequence; no character is dropped. Reset empties the output register and
// returns the sequencer to idle; no clearing pass is needed.

module integer_to_radix_text import itrt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  itrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  itrt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // a taken request blocks the input until its text is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after a request was taken");

  // a character is only written into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_sign || cmd.emit_digit |-> stat.out_free)
    else $error("output register overwritten");

  // input reopens only right after the final digit was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(cmd.emit_digit) && $past(stat.stack_last))
    else $error("input reopened before the text was complete");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for integer_to_radix_text; predicts the character
// stream of each request and checks it under random idling on both sides.
// Depends on itrt_pkg and the integer_to_radix_text RTL.

module tb;
  import itrt_pkg::*;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned CycleLimit   = 1_500_000;
  // longest single conversion (32 binary digits) with margin
  localparam int unsigned SettleCycles = 400;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_data_o;

  out_req_t    expected_chars[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          sender_gaps;
  bit          receiver_stalls;

  integer_to_radix_text #(
    .VALUE_WIDTH(ValueWidth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, expected_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s at cycle %0d: expected %0h, got %0h",
               what, cycle_count, want, got);
    end
  endfunction

  // text of one request: optional '-', then digits most significant first
  function automatic void predict_text(in_req_t req);
    logic [ValueWidth-1:0] raw;
    logic [ValueWidth-1:0] mag;
    logic [ValueWidth-1:0] rem;
    logic [5:0]            base;
    logic [6:0]            glyphs[$];
    bit                    negative;
    out_req_t              ch;
    raw      = req.value[ValueWidth-1:0];
    negative = raw[ValueWidth-1];
    base     = (req.radix < RadixMin || req.radix > RadixMax) ? RadixFallback : req.radix;
    // two's complement magnitude, exact for the most negative value
    mag      = negative ? (~raw + 1'b1) : raw;
    do begin
      rem = mag % base;
      if (rem < DecDigits) begin
        glyphs.push_front(CharZero + rem[6:0]);
      end else begin
        glyphs.push_front((req.upper_letters ? CharUpperA : CharLowerA)
                          + rem[6:0] - {1'b0, DecDigits});
      end
      mag = mag / base;
    end while (mag != 0);
    if (negative) begin
      glyphs.push_front(CharMinus);
    end
    foreach (glyphs[i]) begin
      ch.text_char = glyphs[i];
      ch.last_char = (i == glyphs.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // result side: compare every accepted character with the oldest expectation
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        note_mismatch("unexpected character", 0, 32'(out_data_o));
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.text_char !== want.text_char) begin
          note_mismatch("text_char", 32'(want.text_char), 32'(out_data_o.text_char));
        end
        if (out_data_o.last_char !== want.last_char) begin
          note_mismatch("last_char", 32'(want.last_char), 32'(out_data_o.last_char));
        end
      end
    end
  end

  // receiver stalls in bursts, chosen at random, while receiver_stalls is set
  initial begin
    int burst;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready_i = 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // offer one request, hold it until taken, then record its text
  task automatic send_request(input logic [31:0] value, input logic [5:0] radix,
                              input bit upper);
    int     gap;
    in_req_t req;
    gap = 0;
    req.value         = value;
    req.radix         = radix;
    req.upper_letters = upper;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i              = 1'b0;
      in_data_i.value         = $urandom;
      in_data_i.radix         = 6'($urandom_range(0, 63));
      in_data_i.upper_letters = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_text(req);
  endtask

  task automatic test_zero_and_extremes();
    send_request(32'd0, 6'd10, 1'b0);
    send_request(32'd0, 6'd2, 1'b1);
    send_request(32'h7FFF_FFFF, 6'd2, 1'b0);
    send_request(32'h8000_0000, 6'd2, 1'b1);
    send_request(32'h8000_0000, 6'd10, 1'b0);
    send_request(32'h7FFF_FFFF, 6'd36, 1'b1);
    send_request(32'h8000_0000, 6'd36, 1'b0);
    send_request(32'hFFFF_FFFF, 6'd16, 1'b1);
    send_request(32'd1, 6'd36, 1'b0);
    send_request(32'h8000_0000, 6'd16, 1'b0);
  endtask

  task automatic test_letter_case();
    send_request(32'd35, 6'd36, 1'b1);
    send_request(32'd35, 6'd36, 1'b0);
    send_request(32'hDEAD_BEEF, 6'd16, 1'b1);
    send_request(32'hDEAD_BEEF, 6'd16, 1'b0);
    send_request(32'd10, 6'd11, 1'b0);
    send_request(-32'sd123456789, 6'd36, 1'b1);
  endtask

  task automatic test_radix_fallback();
    send_request(32'd12345, 6'd0, 1'b0);
    send_request(-32'sd987, 6'd1, 1'b1);
    send_request(32'd255, 6'd37, 1'b1);
    send_request(32'h8000_0000, 6'd63, 1'b0);
    send_request(32'd99, 6'd3, 1'b0);
    send_request(32'd7, 6'd2, 1'b0);
    send_request(32'h5555_5555, 6'd35, 1'b1);
    send_request(32'hAAAA_AAAA, 6'd42, 1'b0);
  endtask

  task automatic test_random_requests(input int count);
    logic [31:0] value;
    logic [5:0]  radix;
    int          kind;
    for (int n = 0; n < count; n++) begin
      // idling comes and goes in stretches, and stops for the final part
      sender_gaps     = (n < count - 50) && ((n / 40) % 3 != 2);
      receiver_stalls = sender_gaps;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: value = $urandom;
        4, 5:       value = $urandom_range(0, 40);
        6:          value = -$urandom_range(1, 40);
        7: begin
          if ($urandom_range(0, 1)) value = 32'h7FFF_FFFF - $urandom_range(0, 3);
          else value = 32'h8000_0000 + $urandom_range(0, 3);
        end
        default: begin
          value = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) value = -value;
        end
      endcase
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        radix = 6'($urandom_range(0, 63));
      end else if (kind == 1) begin
        radix = 6'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(37, 63));
      end else begin
        radix = 6'($urandom_range(2, 36));
      end
      send_request(value, radix, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_and_extremes();
    test_letter_case();
    test_radix_fallback();
    test_random_requests(326);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/itrt_pkg.sv
rtl/itrt_ctrl.sv
rtl/itrt_dp.sv
rtl/integer_to_radix_text.sv
tb/sv/tb.sv
